@@ rtl/msgtd_pkg.sv @@
// Shared types, constants and helper functions for the mid/side gain trim dither unit.
package msgtd_pkg;

  localparam int SAMPLE_BITS  = 24;
  localparam int GAIN_BITS    = 16;
  localparam int SEED_BITS    = 32;
  localparam int CFG_IDX_BITS = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_LEFT_GAIN  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RIGHT_GAIN = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MID_GAIN   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SIDE_GAIN  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LEFT_SEED  = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RIGHT_SEED = 3'd5;

  // Reset values
  localparam logic [GAIN_BITS-1:0] LEFT_GAIN_RST  = 16'd8192;
  localparam logic [GAIN_BITS-1:0] RIGHT_GAIN_RST = 16'd8192;
  localparam logic [GAIN_BITS-1:0] MID_GAIN_RST   = 16'd16384;
  localparam logic [GAIN_BITS-1:0] SIDE_GAIN_RST  = 16'd16384;
  localparam logic [SEED_BITS-1:0] LEFT_SEED_RST  = 32'd2463534242;
  localparam logic [SEED_BITS-1:0] RIGHT_SEED_RST = 32'd88675123;

  // Generator midpoint, subtracted to center the dither around zero
  localparam logic [SEED_BITS:0] NOISE_MID = 33'h0_7fff_ffff;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_in;
    logic signed [SAMPLE_BITS-1:0] right_in;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
  } out_item_t;

  // Control of the serial datapath cells
  typedef struct packed {
    logic start;  // initialize carries and accumulators
    logic en;     // advance one bit
  } ser_ctl_t;

  // Control of the result collectors
  typedef struct packed {
    ser_ctl_t ser;
    logic     cap;  // bit belongs to the kept result window
    logic     chk;  // bit lies above the window, check for overflow
  } sat_ctl_t;

  // One xorshift32 step, shifts 13, 17, 5
  function automatic logic [SEED_BITS-1:0] xorshift_step(input logic [SEED_BITS-1:0] x);
    logic [SEED_BITS-1:0] a;
    logic [SEED_BITS-1:0] b;
    a = x ^ (x << 13);
    b = a ^ (a >> 17);
    return b ^ (b << 5);
  endfunction

  // A zero seed would lock the generator; load one instead
  function automatic logic [SEED_BITS-1:0] seed_value(input logic [SEED_BITS-1:0] s);
    return (s == '0) ? {{(SEED_BITS-1){1'b0}}, 1'b1} : s;
  endfunction

endpackage

@@ rtl/msgtd_ser_add.sv @@
// Bit-serial adder/subtractor, LSB first, one carry flop.
module msgtd_ser_add (
  input  logic                clk,
  input  msgtd_pkg::ser_ctl_t ctl,
  input  logic                sub,
  input  logic                a_bit,
  input  logic                b_bit,
  output logic                sum_bit
);

  logic carry_r;
  logic carry_nxt;
  logic b_eff;

  // Subtract as a + ~b + 1
  assign b_eff     = b_bit ^ sub;
  assign sum_bit   = a_bit ^ b_eff ^ carry_r;
  assign carry_nxt = (a_bit & b_eff) | (a_bit & carry_r) | (b_eff & carry_r);

  // Seed the carry, then advance one bit per cycle while enabled
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      carry_r <= sub;
    end else if (ctl.en) begin
      carry_r <= carry_nxt;
    end
  end

endmodule

@@ rtl/msgtd_ser_mul.sv @@
// Serial-parallel multiplier: serial two's complement stream times an unsigned gain.
module msgtd_ser_mul (
  input  logic                             clk,
  input  msgtd_pkg::ser_ctl_t              ctl,
  input  logic [msgtd_pkg::GAIN_BITS-1:0]  coef,
  input  logic                             x_bit,
  output logic                             p_bit
);

  logic [msgtd_pkg::GAIN_BITS-1:0] acc_r;
  logic [msgtd_pkg::GAIN_BITS-1:0] acc_nxt;
  logic [msgtd_pkg::GAIN_BITS:0]   sum;

  // Add the gain when the stream bit is set, emit the low bit, keep the rest
  assign sum     = {1'b0, acc_r} + (x_bit ? {1'b0, coef} : '0);
  assign p_bit   = sum[0];
  assign acc_nxt = sum[msgtd_pkg::GAIN_BITS:1];

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      acc_r <= '0;
    end else if (ctl.en) begin
      acc_r <= acc_nxt;
    end
  end

endmodule

@@ rtl/msgtd_dither.sv @@
// Dither term: centers the generator word, scales it to the product's LSB and streams it out.
module msgtd_dither #(
  parameter int FRAC_BITS = 14
) (
  input  logic                             clk,
  input  msgtd_pkg::ser_ctl_t              ctl,
  input  logic [msgtd_pkg::SEED_BITS-1:0]  noise,
  output logic                             d_bit
);

  localparam int K  = 2 * FRAC_BITS;
  localparam int DW = (K > 31) ? K + 2 : 33;

  logic signed [msgtd_pkg::SEED_BITS:0] n_val;
  logic [DW-1:0]                        d_load;
  logic [DW-1:0]                        d_sr_r;

  // Center the word around zero
  assign n_val = $signed({1'b0, noise} - msgtd_pkg::NOISE_MID);

  // Align to 2^-31 of an output LSB: floor toward minus infinity, or pad with zeros
  generate
    if (K > 31) begin : g_up
      assign d_load = {n_val, {(K-31){1'b0}}};
    end else begin : g_down
      logic signed [msgtd_pkg::SEED_BITS:0] n_shr;
      assign n_shr  = n_val >>> (31 - K);
      assign d_load = n_shr;
    end
  endgenerate

  // Load at start, then shift right keeping the sign for endless extension
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      d_sr_r <= d_load;
    end else if (ctl.en) begin
      d_sr_r <= {d_sr_r[DW-1], d_sr_r[DW-1:1]};
    end
  end

  assign d_bit = d_sr_r[0];

endmodule

@@ rtl/msgtd_sat.sv @@
// Result collector: keeps the output bit window of the serial sum and saturates it.
module msgtd_sat (
  input  logic                                    clk,
  input  msgtd_pkg::sat_ctl_t                     ctl,
  input  logic                                    t_bit,
  output logic signed [msgtd_pkg::SAMPLE_BITS-1:0] y
);

  localparam int S = msgtd_pkg::SAMPLE_BITS;

  logic [S-1:0] y_sr_r;
  logic         ovf_r;
  logic         sign_r;

  // Capture the window, flag any higher bit that differs from its top bit
  always_ff @(posedge clk) begin
    if (ctl.ser.start) begin
      ovf_r <= 1'b0;
    end else if (ctl.ser.en) begin
      sign_r <= t_bit;
      if (ctl.cap) begin
        y_sr_r <= {t_bit, y_sr_r[S-1:1]};
      end
      if (ctl.chk && (t_bit != y_sr_r[S-1])) begin
        ovf_r <= 1'b1;
      end
    end
  end

  // Clip to the nearest limit on overflow
  assign y = ovf_r ? {sign_r, {(S-1){~sign_r}}} : y_sr_r;

endmodule

@@ rtl/mid_side_gain_trim_dither_unit.sv @@
// Top level of the mid/side gain trim unit with xorshift dither, bit-serial datapath.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+----------------------------------
//  in      | input     | in_valid/in_stall  | in_data   (left_in, right_in)
//  out     | output    | out_valid/out_stall| out_data  (left_out, right_out)
//  cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// An item is accepted, then streamed one result bit per cycle through the serial
// adders and multipliers, and then handed to the output register once that is free.
// Reset (synchronous, rst_n low) restores gains and generator states; no clearing pass.
// A stalled output holds in its register while the next item is already computed.
module mid_side_gain_trim_dither_unit #(
  parameter int GAIN_FRAC_BITS = 14
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  msgtd_pkg::in_item_t                  in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output msgtd_pkg::out_item_t                 out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [msgtd_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [msgtd_pkg::SEED_BITS-1:0]      cfg_data
);

  localparam int S       = msgtd_pkg::SAMPLE_BITS;
  localparam int GB      = msgtd_pkg::GAIN_BITS;
  localparam int SB      = msgtd_pkg::SEED_BITS;
  localparam int K       = 2 * GAIN_FRAC_BITS;
  localparam int NBITS   = S + ((K > 35) ? K : 35);
  localparam int CNT_W   = $clog2(NBITS);
  localparam logic [CNT_W-1:0] LAST    = CNT_W'(NBITS - 1);
  localparam logic [CNT_W-1:0] RND_POS = CNT_W'(K - 1);
  localparam logic [CNT_W-1:0] CAP_LO  = CNT_W'(K);
  localparam logic [CNT_W-1:0] CAP_HI  = CNT_W'(K + S - 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t                state_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [S-1:0]          l_sr_r;
  logic [S-1:0]          r_sr_r;
  logic [GB-1:0]         left_gain_r;
  logic [GB-1:0]         right_gain_r;
  logic [GB-1:0]         mid_gain_r;
  logic [GB-1:0]         side_gain_r;
  logic [SB-1:0]         lnoise_r;
  logic [SB-1:0]         rnoise_r;
  logic [SB-1:0]         lnoise_nxt;
  logic [SB-1:0]         rnoise_nxt;
  logic                  out_valid_r;
  msgtd_pkg::out_item_t  out_data_r;

  logic                  in_acc;
  logic                  cfg_wr;
  logic                  run;
  logic                  out_load;
  logic                  rnd_bit;
  msgtd_pkg::ser_ctl_t   ser_ctl;
  msgtd_pkg::sat_ctl_t   sat_ctl;

  logic a_bit, b_bit, m_bit, sd_bit, sl_bit, sr_bit, pl_bit, pr_bit;
  logic dl_bit, dr_bit, ql_bit, qr_bit, tl_bit, tr_bit;
  logic signed [S-1:0] y_l;
  logic signed [S-1:0] y_r;

  assign in_acc    = in_valid && (state_r == ST_IDLE);
  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid;
  assign run       = (state_r == ST_RUN);
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  assign ser_ctl.start = in_acc;
  assign ser_ctl.en    = run;
  assign sat_ctl.ser   = ser_ctl;
  assign sat_ctl.cap   = (cnt_r >= CAP_LO) && (cnt_r <= CAP_HI);
  assign sat_ctl.chk   = (cnt_r > CAP_HI);
  assign rnd_bit       = run && (cnt_r == RND_POS);

  // Sequence: accept, stream the bits, hand off the result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            state_r <= ST_RUN;
            cnt_r   <= '0;
          end
        end
        ST_RUN: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == LAST) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid_r || !out_stall) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Write the gain registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_gain_r  <= msgtd_pkg::LEFT_GAIN_RST;
      right_gain_r <= msgtd_pkg::RIGHT_GAIN_RST;
      mid_gain_r   <= msgtd_pkg::MID_GAIN_RST;
      side_gain_r  <= msgtd_pkg::SIDE_GAIN_RST;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        msgtd_pkg::CFG_LEFT_GAIN:  left_gain_r  <= cfg_data[GB-1:0];
        msgtd_pkg::CFG_RIGHT_GAIN: right_gain_r <= cfg_data[GB-1:0];
        msgtd_pkg::CFG_MID_GAIN:   mid_gain_r   <= cfg_data[GB-1:0];
        msgtd_pkg::CFG_SIDE_GAIN:  side_gain_r  <= cfg_data[GB-1:0];
        default: begin
        end
      endcase
    end
  end

  // Step the generators on accept, reload them on a seed write
  assign lnoise_nxt = msgtd_pkg::xorshift_step(lnoise_r);
  assign rnoise_nxt = msgtd_pkg::xorshift_step(rnoise_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lnoise_r <= msgtd_pkg::seed_value(msgtd_pkg::LEFT_SEED_RST);
      rnoise_r <= msgtd_pkg::seed_value(msgtd_pkg::RIGHT_SEED_RST);
    end else begin
      if (cfg_wr && (cfg_index == msgtd_pkg::CFG_LEFT_SEED)) begin
        lnoise_r <= msgtd_pkg::seed_value(cfg_data);
      end else if (in_acc) begin
        lnoise_r <= lnoise_nxt;
      end
      if (cfg_wr && (cfg_index == msgtd_pkg::CFG_RIGHT_SEED)) begin
        rnoise_r <= msgtd_pkg::seed_value(cfg_data);
      end else if (in_acc) begin
        rnoise_r <= rnoise_nxt;
      end
    end
  end

  // Load the samples, then shift them out LSB first with sign extension
  always_ff @(posedge clk) begin
    if (in_acc) begin
      l_sr_r <= in_data.left_in;
      r_sr_r <= in_data.right_in;
    end else if (run) begin
      l_sr_r <= {l_sr_r[S-1], l_sr_r[S-1:1]};
      r_sr_r <= {r_sr_r[S-1], r_sr_r[S-1:1]};
    end
  end

  // Mid and side
  msgtd_ser_add u_add_mid  (.clk(clk), .ctl(ser_ctl), .sub(1'b0),
                            .a_bit(l_sr_r[0]), .b_bit(r_sr_r[0]), .sum_bit(a_bit));
  msgtd_ser_add u_add_side (.clk(clk), .ctl(ser_ctl), .sub(1'b1),
                            .a_bit(l_sr_r[0]), .b_bit(r_sr_r[0]), .sum_bit(b_bit));

  // Mid and side gains
  msgtd_ser_mul u_mul_mid  (.clk(clk), .ctl(ser_ctl), .coef(mid_gain_r),
                            .x_bit(a_bit), .p_bit(m_bit));
  msgtd_ser_mul u_mul_side (.clk(clk), .ctl(ser_ctl), .coef(side_gain_r),
                            .x_bit(b_bit), .p_bit(sd_bit));

  // Back to left and right
  msgtd_ser_add u_add_l (.clk(clk), .ctl(ser_ctl), .sub(1'b0),
                         .a_bit(m_bit), .b_bit(sd_bit), .sum_bit(sl_bit));
  msgtd_ser_add u_add_r (.clk(clk), .ctl(ser_ctl), .sub(1'b1),
                         .a_bit(m_bit), .b_bit(sd_bit), .sum_bit(sr_bit));

  // Output gains
  msgtd_ser_mul u_mul_l (.clk(clk), .ctl(ser_ctl), .coef(left_gain_r),
                         .x_bit(sl_bit), .p_bit(pl_bit));
  msgtd_ser_mul u_mul_r (.clk(clk), .ctl(ser_ctl), .coef(right_gain_r),
                         .x_bit(sr_bit), .p_bit(pr_bit));

  // Dither streams from the freshly stepped generators
  msgtd_dither #(.FRAC_BITS(GAIN_FRAC_BITS)) u_dith_l (
    .clk(clk), .ctl(ser_ctl), .noise(lnoise_nxt), .d_bit(dl_bit));
  msgtd_dither #(.FRAC_BITS(GAIN_FRAC_BITS)) u_dith_r (
    .clk(clk), .ctl(ser_ctl), .noise(rnoise_nxt), .d_bit(dr_bit));

  // Add dither, then the rounding half
  msgtd_ser_add u_add_dl (.clk(clk), .ctl(ser_ctl), .sub(1'b0),
                          .a_bit(pl_bit), .b_bit(dl_bit), .sum_bit(ql_bit));
  msgtd_ser_add u_add_dr (.clk(clk), .ctl(ser_ctl), .sub(1'b0),
                          .a_bit(pr_bit), .b_bit(dr_bit), .sum_bit(qr_bit));
  msgtd_ser_add u_add_rl (.clk(clk), .ctl(ser_ctl), .sub(1'b0),
                          .a_bit(ql_bit), .b_bit(rnd_bit), .sum_bit(tl_bit));
  msgtd_ser_add u_add_rr (.clk(clk), .ctl(ser_ctl), .sub(1'b0),
                          .a_bit(qr_bit), .b_bit(rnd_bit), .sum_bit(tr_bit));

  // Collect and saturate
  msgtd_sat u_sat_l (.clk(clk), .ctl(sat_ctl), .t_bit(tl_bit), .y(y_l));
  msgtd_sat u_sat_r (.clk(clk), .ctl(sat_ctl), .t_bit(tr_bit), .y(y_r));

  // Output register: fill when empty or being drained, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.left_out  <= y_l;
      out_data_r.right_out <= y_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for the mid/side gain trim unit with xorshift dither.
`timescale 1ns / 1ps

module tb_top;

  localparam int SAMPLE_BITS     = msgtd_pkg::SAMPLE_BITS;
  localparam int GAIN_BITS       = msgtd_pkg::GAIN_BITS;
  localparam int SEED_BITS       = msgtd_pkg::SEED_BITS;
  localparam int CFG_IDX_BITS    = msgtd_pkg::CFG_IDX_BITS;

  localparam int FRAC            = 14;
  localparam int PHASES          = 8;
  localparam int PAIRS_PER_PHASE = 210;
  localparam int LONG_HOLD       = 400;
  localparam int DRAIN_CYCLES    = 80;
  localparam int MAX_REPORTS     = 10;

  // Indexes past the register map; writes there must change nothing
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_HI = 3'd7;

  localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam longint OUT_MAX      = (longint'(1) <<< (SAMPLE_BITS-1)) - 1;
  localparam longint OUT_MIN      = -OUT_MAX - 1;
  localparam longint NOISE_CENTER = 64'sh7fff_ffff;

  typedef enum logic {ROW_PAIR, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t                kind;
    logic [CFG_IDX_BITS-1:0]  idx;
    logic [SEED_BITS-1:0]     val;
    msgtd_pkg::in_item_t      pair;
    bit                       typed;
    msgtd_pkg::out_item_t     want;
  } dir_row_t;

  logic                    clk;
  logic                    rst_n     = 1'b0;
  logic                    in_valid  = 1'b0;
  logic                    in_stall;
  msgtd_pkg::in_item_t     in_data   = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  msgtd_pkg::out_item_t    out_data;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [SEED_BITS-1:0]    cfg_data  = '0;

  // Shadow of the block's registers and generator states
  logic [GAIN_BITS-1:0] gain_left, gain_right, gain_mid, gain_side;
  logic [SEED_BITS-1:0] seed_left, seed_right, noise_left, noise_right;

  msgtd_pkg::out_item_t pending_pairs[$];
  msgtd_pkg::out_item_t want_pair;
  dir_row_t             dir_rows[$];

  int  mismatch_cnt   = 0;
  int  results_seen   = 0;
  int  pairs_sent     = 0;
  int  reg_writes     = 0;
  int  rx_gap         = 0;
  bit  tx_idle_on     = 1'b1;
  logic rx_idle_on    = 1'b1;
  logic rx_hold       = 1'b0;
  bit  hold_go        = 1'b0;

  mid_side_gain_trim_dither_unit #(.GAIN_FRAC_BITS(FRAC)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [SEED_BITS-1:0] noise_next(logic [SEED_BITS-1:0] x);
    x = x ^ (x << 13);
    x = x ^ (x >> 17);
    x = x ^ (x << 5);
    return x;
  endfunction

  // Scale one channel, add centered dither, round half up and clip
  function automatic logic signed [SAMPLE_BITS-1:0] clip_channel(
    longint mix, logic [GAIN_BITS-1:0] gain, logic [SEED_BITS-1:0] noise);
    longint dith;
    longint acc;
    dith = (longint'({32'd0, noise}) - NOISE_CENTER) >>> (31 - 2*FRAC);
    acc  = (mix * longint'({48'd0, gain}) + dith + (longint'(1) <<< (2*FRAC - 1)))
           >>> (2*FRAC);
    if (acc > OUT_MAX) acc = OUT_MAX;
    else if (acc < OUT_MIN) acc = OUT_MIN;
    return acc[SAMPLE_BITS-1:0];
  endfunction

  // Advance both generators, then form the trimmed stereo pair
  function automatic msgtd_pkg::out_item_t trim_pair(msgtd_pkg::in_item_t x);
    longint               l_s;
    longint               r_s;
    longint               mid_t;
    longint               side_t;
    msgtd_pkg::out_item_t y;
    l_s    = longint'(x.left_in);
    r_s    = longint'(x.right_in);
    mid_t  = (l_s + r_s) * longint'({48'd0, gain_mid});
    side_t = (l_s - r_s) * longint'({48'd0, gain_side});
    noise_left  = noise_next(noise_left);
    noise_right = noise_next(noise_right);
    y.left_out  = clip_channel(mid_t + side_t, gain_left, noise_left);
    y.right_out = clip_channel(mid_t - side_t, gain_right, noise_right);
    return y;
  endfunction

  // Mirror a register write; a seed also reloads its generator, zero loads one
  function automatic void shadow_write(logic [CFG_IDX_BITS-1:0] idx,
                                       logic [SEED_BITS-1:0] val);
    case (idx)
      msgtd_pkg::CFG_LEFT_GAIN:  gain_left  = val[GAIN_BITS-1:0];
      msgtd_pkg::CFG_RIGHT_GAIN: gain_right = val[GAIN_BITS-1:0];
      msgtd_pkg::CFG_MID_GAIN:   gain_mid   = val[GAIN_BITS-1:0];
      msgtd_pkg::CFG_SIDE_GAIN:  gain_side  = val[GAIN_BITS-1:0];
      msgtd_pkg::CFG_LEFT_SEED: begin
        seed_left  = val;
        noise_left = (val == '0) ? 32'd1 : val;
      end
      msgtd_pkg::CFG_RIGHT_SEED: begin
        seed_right  = val;
        noise_right = (val == '0) ? 32'd1 : val;
      end
      default: ;
    endcase
  endfunction

  function automatic void shadow_reset();
    gain_left   = msgtd_pkg::LEFT_GAIN_RST;
    gain_right  = msgtd_pkg::RIGHT_GAIN_RST;
    gain_mid    = msgtd_pkg::MID_GAIN_RST;
    gain_side   = msgtd_pkg::SIDE_GAIN_RST;
    seed_left   = msgtd_pkg::LEFT_SEED_RST;
    seed_right  = msgtd_pkg::RIGHT_SEED_RST;
    noise_left  = msgtd_pkg::LEFT_SEED_RST;
    noise_right = msgtd_pkg::RIGHT_SEED_RST;
  endfunction

  // ---------------------------------------------------------------- directed rows

  function automatic void add_pair(logic signed [SAMPLE_BITS-1:0] l,
                                   logic signed [SAMPLE_BITS-1:0] r);
    dir_row_t row;
    row = '{kind: ROW_PAIR, idx: '0, val: '0, pair: '0, typed: 1'b0, want: '0};
    row.pair.left_in  = l;
    row.pair.right_in = r;
    dir_rows.push_back(row);
  endfunction

  function automatic void add_clipped(logic signed [SAMPLE_BITS-1:0] l,
                                      logic signed [SAMPLE_BITS-1:0] r,
                                      logic signed [SAMPLE_BITS-1:0] wl,
                                      logic signed [SAMPLE_BITS-1:0] wr);
    add_pair(l, r);
    dir_rows[$].typed          = 1'b1;
    dir_rows[$].want.left_out  = wl;
    dir_rows[$].want.right_out = wr;
  endfunction

  function automatic void add_reg(logic [CFG_IDX_BITS-1:0] idx, logic [SEED_BITS-1:0] val);
    dir_row_t row;
    row = '{kind: ROW_REG, idx: idx, val: val, pair: '0, typed: 1'b0, want: '0};
    dir_rows.push_back(row);
  endfunction

  // ---------------------------------------------------------------- random draws

  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return S_MAX;
      1: return S_MIN;
      2: return SAMPLE_BITS'($signed($urandom_range(0, 512)) - 256);
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [GAIN_BITS-1:0] pick_gain(logic [GAIN_BITS-1:0] nominal);
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return nominal;
      3: return GAIN_BITS'($urandom);
      default: return GAIN_BITS'($urandom_range(int'(nominal) / 2, int'(nominal) * 3 / 2));
    endcase
  endfunction

  function automatic logic [SEED_BITS-1:0] pick_seed();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  // ---------------------------------------------------------------- drivers

  // Offer one pair after a random gap; predict it once the block takes it
  task automatic send_pair(msgtd_pkg::in_item_t x, bit typed, msgtd_pkg::out_item_t want);
    int gap;
    msgtd_pkg::out_item_t got;
    gap = tx_idle_on ? $urandom_range(0, 14) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= x;
    do @(posedge clk); while (in_stall);
    got = trim_pair(x);
    pending_pairs.push_back(typed ? want : got);
    pairs_sent++;
  endtask

  // Hold cfg_valid high across back-to-back writes; caller lowers it
  task automatic reg_write(logic [CFG_IDX_BITS-1:0] idx, logic [SEED_BITS-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    shadow_write(idx, val);
    reg_writes++;
  endtask

  task automatic wait_drained();
    while (pending_pairs.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- receiver

  // Draw a stall after each taken result; a long hold overrides it
  always @(posedge clk) begin : rx_pace
    int g;
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_gap    <= 0;
    end else if (out_valid && !out_stall) begin
      g = rx_idle_on ? $urandom_range(0, 14) : 0;
      rx_gap    <= g;
      out_stall <= rx_hold || (g != 0);
    end else begin
      if (rx_gap != 0) rx_gap <= rx_gap - 1;
      out_stall <= rx_hold || (rx_gap > 1);
    end
  end

  // Block the output for a long stretch so the input side backs up
  initial begin
    wait (hold_go);
    rx_hold <= 1'b1;
    repeat (LONG_HOLD) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // Compare each taken result with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_pairs.size() == 0) begin
        if (mismatch_cnt < MAX_REPORTS)
          $display("unexpected result: left %0d right %0d",
                   out_data.left_out, out_data.right_out);
        mismatch_cnt++;
      end else begin
        want_pair = pending_pairs.pop_front();
        if (out_data.left_out !== want_pair.left_out ||
            out_data.right_out !== want_pair.right_out) begin
          if (mismatch_cnt < MAX_REPORTS)
            $display("mismatch at result %0d: left exp %0d got %0d, right exp %0d got %0d",
                     results_seen, want_pair.left_out, out_data.left_out,
                     want_pair.right_out, out_data.right_out);
          mismatch_cnt++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    msgtd_pkg::in_item_t x;
    bit                  reg_open;
    shadow_reset();
    reg_open = 1'b0;

    // Reset values first, then full-scale gains where results clip for sure
    add_pair('0, '0);
    add_pair(S_MAX, S_MAX);
    add_pair(S_MIN, S_MIN);
    add_pair(S_MAX, S_MIN);
    add_pair(S_MIN, S_MAX);
    add_pair(24'sd1, -24'sd1);
    add_reg(msgtd_pkg::CFG_LEFT_GAIN,  32'hffff_ffff);
    add_reg(msgtd_pkg::CFG_RIGHT_GAIN, 32'h0001_ffff);
    add_reg(msgtd_pkg::CFG_MID_GAIN,   32'h0000_ffff);
    add_reg(msgtd_pkg::CFG_SIDE_GAIN,  32'h5a5a_ffff);
    add_clipped(S_MAX, S_MAX, S_MAX, S_MAX);
    add_clipped(S_MIN, S_MIN, S_MIN, S_MIN);
    add_clipped(S_MAX, S_MIN, S_MAX, S_MIN);
    add_clipped(S_MIN, S_MAX, S_MIN, S_MAX);
    add_reg(CFG_SPARE_LO, 32'h0000_0000);
    add_reg(CFG_SPARE_HI, 32'h0000_0000);
    add_clipped(S_MAX, S_MAX, S_MAX, S_MAX);
    // Zero seed falls back to one; all-ones seed is a plain value
    add_reg(msgtd_pkg::CFG_LEFT_SEED,  32'h0000_0000);
    add_reg(msgtd_pkg::CFG_RIGHT_SEED, 32'hffff_ffff);
    add_pair('0, '0);
    add_pair(S_MAX, 24'sd0);
    // Zero gains leave only the dither
    add_reg(msgtd_pkg::CFG_LEFT_GAIN,  32'h0);
    add_reg(msgtd_pkg::CFG_RIGHT_GAIN, 32'h0);
    add_reg(msgtd_pkg::CFG_MID_GAIN,   32'h0);
    add_reg(msgtd_pkg::CFG_SIDE_GAIN,  32'h0);
    add_pair(S_MAX, S_MIN);
    add_pair(S_MIN, S_MIN);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the directed rows
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_REG) begin
        if (!reg_open) begin
          in_valid <= 1'b0;
          wait_drained();
        end
        reg_write(dir_rows[i].idx, dir_rows[i].val);
        reg_open = 1'b1;
      end else begin
        if (reg_open) begin
          cfg_valid <= 1'b0;
          reg_open = 1'b0;
        end
        send_pair(dir_rows[i].pair, dir_rows[i].typed, dir_rows[i].want);
      end
    end
    if (reg_open) cfg_valid <= 1'b0;

    // Random phases, each under its own gains, with new seeds on even phases and varied pacing
    for (int ph = 0; ph < PHASES; ph++) begin
      in_valid <= 1'b0;
      wait_drained();
      case (ph)
        0: begin
          reg_write(msgtd_pkg::CFG_LEFT_GAIN,  {16'($urandom), 16'h0000});
          reg_write(msgtd_pkg::CFG_RIGHT_GAIN, {16'($urandom), 16'h0000});
          reg_write(msgtd_pkg::CFG_MID_GAIN,   {16'($urandom), 16'hffff});
          reg_write(msgtd_pkg::CFG_SIDE_GAIN,  {16'($urandom), 16'hffff});
        end
        1: begin
          reg_write(msgtd_pkg::CFG_LEFT_GAIN,  32'h0000_ffff);
          reg_write(msgtd_pkg::CFG_RIGHT_GAIN, 32'h0000_ffff);
          reg_write(msgtd_pkg::CFG_MID_GAIN,   32'h0000_ffff);
          reg_write(msgtd_pkg::CFG_SIDE_GAIN,  32'h0000_ffff);
        end
        default: begin
          reg_write(msgtd_pkg::CFG_LEFT_GAIN,
                    {16'($urandom), pick_gain(msgtd_pkg::LEFT_GAIN_RST)});
          reg_write(msgtd_pkg::CFG_RIGHT_GAIN,
                    {16'($urandom), pick_gain(msgtd_pkg::RIGHT_GAIN_RST)});
          reg_write(msgtd_pkg::CFG_MID_GAIN,
                    {16'($urandom), pick_gain(msgtd_pkg::MID_GAIN_RST)});
          reg_write(msgtd_pkg::CFG_SIDE_GAIN,
                    {16'($urandom), pick_gain(msgtd_pkg::SIDE_GAIN_RST)});
        end
      endcase
      // Odd phases keep the generators running on from the last phase
      if (ph % 2 == 0) begin
        reg_write(msgtd_pkg::CFG_LEFT_SEED,  pick_seed());
        reg_write(msgtd_pkg::CFG_RIGHT_SEED, pick_seed());
      end
      if (ph % 3 == 0) reg_write(($urandom_range(0, 1) != 0) ? CFG_SPARE_LO : CFG_SPARE_HI,
                                 $urandom);
      cfg_valid <= 1'b0;

      tx_idle_on = (ph % 4) != 2;
      rx_idle_on <= (ph % 4) != 2;
      if (ph == 3) hold_go = 1'b1;

      for (int k = 0; k < PAIRS_PER_PHASE; k++) begin
        x.left_in  = pick_sample();
        x.right_in = ($urandom_range(0, 5) == 0) ? x.left_in : pick_sample();
        send_pair(x, 1'b0, '0);
      end
    end
    in_valid <= 1'b0;

    // Drain, then watch for stray results
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d stereo pairs and %0d register writes over %0d random settings",
             pairs_sent, reg_writes, PHASES);
    $display("%0d results checked, %0d mismatches", results_seen, mismatch_cnt);
    if (mismatch_cnt == 0 && pending_pairs.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

@@ mid_side_gain_trim_dither_unit.f @@
rtl/msgtd_pkg.sv
rtl/msgtd_ser_add.sv
rtl/msgtd_ser_mul.sv
rtl/msgtd_dither.sv
rtl/msgtd_sat.sv
rtl/mid_side_gain_trim_dither_unit.sv
test/tb_top.sv
